// ===== sv/cmp_pkg.sv =====
package cmp_pkg;

  // Width of the rotation datapath and of the angle accumulator.
  localparam int ACC_W = 36;
  localparam int GUARD_BITS = 16;
  localparam int ABS_W = 17;

  localparam int SQRT_STEPS = 16;
  // Squares, sum, one register per root bit, rounding.
  localparam int MAG_LAT = SQRT_STEPS + 3;

  localparam int PHASE_FRAC_BITS = 13;
  localparam int PHASE_SHIFT = 32 - PHASE_FRAC_BITS;

  localparam logic [ACC_W-1:0] HALF_PI_Q32 = 36'd6746518852;
  localparam logic [ACC_W-1:0] PI_Q32 = 36'd13493037705;
  localparam logic [ACC_W-1:0] THREE_HALF_PI_Q32 = 36'd20239556557;
  localparam logic [ACC_W-1:0] TWO_PI_Q32 = 36'd26986075409;
  localparam logic [ACC_W:0] PHASE_TOP = {1'b0, TWO_PI_Q32} >> PHASE_SHIFT;

  localparam logic [15:0] MAG_MAX = 16'd46341;

  typedef struct packed {
    logic re_neg;
    logic re_zero;
    logic im_neg;
    logic im_zero;
  } quad_t;

  // Arctangent of 2^-idx in radians with 32 fractional bits, rounded to nearest.
  function automatic logic [31:0] atan_q32(input int unsigned idx);
    logic [31:0] val;
    unique case (idx)
      0: val = 32'd3373259426;
      1: val = 32'd1991351318;
      2: val = 32'd1052175346;
      3: val = 32'd534100635;
      4: val = 32'd268086748;
      5: val = 32'd134174063;
      6: val = 32'd67103403;
      7: val = 32'd33553749;
      8: val = 32'd16777131;
      9: val = 32'd8388597;
      10: val = 32'd4194303;
      default: val = 32'(64'd1 << (32 - idx));
    endcase
    return val;
  endfunction

endpackage

// ===== sv/cmp_sqrt.sv =====
module cmp_sqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [cmp_pkg::ABS_W-1:0]  ax,
  input  logic [cmp_pkg::ABS_W-1:0]  ay,
  output logic                       out_valid,
  output logic [15:0]                magnitude
);

  localparam int STEPS = cmp_pkg::SQRT_STEPS;
  localparam int RAD_W = 2 * STEPS;
  localparam int ROOT_W = STEPS;
  localparam int REM_W = STEPS + 1;
  localparam int SQ_W = 2 * cmp_pkg::ABS_W;

  logic [SQ_W-1:0] sq_x;
  logic [SQ_W-1:0] sq_y;
  logic            sq_valid;

  logic [RAD_W-1:0]  rad  [STEPS+1];
  logic [ROOT_W-1:0] root [STEPS+1];
  logic [REM_W-1:0]  rem  [STEPS+1];
  logic [STEPS:0]    vld;

  always_ff @(posedge clk) begin
    sq_x <= {{cmp_pkg::ABS_W{1'b0}}, ax} * {{cmp_pkg::ABS_W{1'b0}}, ax};
    sq_y <= {{cmp_pkg::ABS_W{1'b0}}, ay} * {{cmp_pkg::ABS_W{1'b0}}, ay};
    rad[0] <= {1'b0, sq_x[RAD_W-2:0]} + {1'b0, sq_y[RAD_W-2:0]};
    root[0] <= '0;
    rem[0] <= '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid <= 1'b0;
      vld[0] <= 1'b0;
    end else begin
      sq_valid <= in_valid;
      vld[0] <= sq_valid;
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic [REM_W+1:0] rem_sh;
    logic [REM_W:0]   trial;
    logic             fits;

    assign rem_sh = {rem[k], rad[k][RAD_W-1:RAD_W-2]};
    assign trial = {root[k], 2'b01};
    assign fits = rem_sh >= {1'b0, trial};

    always_ff @(posedge clk) begin
      rem[k+1] <= fits ? REM_W'(rem_sh - {1'b0, trial}) : REM_W'(rem_sh);
      root[k+1] <= {root[k][ROOT_W-2:0], fits};
      rad[k+1] <= {rad[k][RAD_W-3:0], 2'b00};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rem[STEPS] > {1'b0, root[STEPS]}) begin
      magnitude <= root[STEPS] + 16'd1;
    end else begin
      magnitude <= root[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vld[STEPS];
    end
  end

endmodule

// ===== sv/cmp_cordic.sv =====
module cmp_cordic #(
  parameter int ROTATION_STAGES = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [cmp_pkg::ABS_W-1:0]  ax,
  input  logic [cmp_pkg::ABS_W-1:0]  ay,
  input  cmp_pkg::quad_t             quad,
  output logic                       out_valid,
  output logic [15:0]                phase_angle
);

  localparam int W = cmp_pkg::ACC_W;
  localparam int PAD_W = W - cmp_pkg::ABS_W - cmp_pkg::GUARD_BITS;

  logic signed [W-1:0] x [ROTATION_STAGES+1];
  logic signed [W-1:0] y [ROTATION_STAGES+1];
  logic signed [W-1:0] z [ROTATION_STAGES+1];
  cmp_pkg::quad_t      q [ROTATION_STAGES+1];
  logic [ROTATION_STAGES:0] vld;

  logic [W-1:0] th;
  logic [W-1:0] acc;
  logic [W-1:0] acc_next;
  logic         acc_valid;
  logic [W:0]   rounded;
  logic [W:0]   code;

  assign x[0] = signed'({{PAD_W{1'b0}}, ax, {cmp_pkg::GUARD_BITS{1'b0}}});
  assign y[0] = signed'({{PAD_W{1'b0}}, ay, {cmp_pkg::GUARD_BITS{1'b0}}});
  assign z[0] = '0;
  assign q[0] = quad;
  assign vld[0] = in_valid;

  for (genvar i = 0; i < ROTATION_STAGES; i++) begin : g_rot
    localparam logic signed [W-1:0] ATAN_I = signed'(W'(cmp_pkg::atan_q32(i)));
    logic signed [W-1:0] xs;
    logic signed [W-1:0] ys;

    assign xs = x[i] >>> i;
    assign ys = y[i] >>> i;

    always_ff @(posedge clk) begin
      if (!y[i][W-1]) begin
        x[i+1] <= x[i] + ys;
        y[i+1] <= y[i] - xs;
        z[i+1] <= z[i] + ATAN_I;
      end else begin
        x[i+1] <= x[i] - ys;
        y[i+1] <= y[i] + xs;
        z[i+1] <= z[i] - ATAN_I;
      end
      q[i+1] <= q[i];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
    end
  end

  always_comb begin
    priority if (z[ROTATION_STAGES][W-1]) begin
      th = '0;
    end else if (unsigned'(z[ROTATION_STAGES]) > cmp_pkg::HALF_PI_Q32) begin
      th = cmp_pkg::HALF_PI_Q32;
    end else begin
      th = unsigned'(z[ROTATION_STAGES]);
    end
  end

  always_comb begin
    cmp_pkg::quad_t qf;
    qf = q[ROTATION_STAGES];
    priority if (qf.re_zero && qf.im_zero) begin
      acc_next = '0;
    end else if (qf.im_zero) begin
      acc_next = qf.re_neg ? cmp_pkg::PI_Q32 : '0;
    end else if (qf.re_zero) begin
      acc_next = qf.im_neg ? cmp_pkg::THREE_HALF_PI_Q32 : cmp_pkg::HALF_PI_Q32;
    end else if (!qf.re_neg && !qf.im_neg) begin
      acc_next = th;
    end else if (qf.re_neg && !qf.im_neg) begin
      acc_next = cmp_pkg::PI_Q32 - th;
    end else if (qf.re_neg) begin
      acc_next = cmp_pkg::PI_Q32 + th;
    end else begin
      acc_next = cmp_pkg::TWO_PI_Q32 - th;
    end
  end

  assign rounded = {1'b0, acc} + ((W+1)'(1) << (cmp_pkg::PHASE_SHIFT - 1));
  assign code = rounded >> cmp_pkg::PHASE_SHIFT;

  always_ff @(posedge clk) begin
    acc <= acc_next;
    if (code > cmp_pkg::PHASE_TOP) begin
      phase_angle <= cmp_pkg::PHASE_TOP[15:0];
    end else begin
      phase_angle <= code[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      acc_valid <= vld[ROTATION_STAGES];
      out_valid <= acc_valid;
    end
  end

endmodule

// ===== sv/complex_magnitude_phase.sv =====
// Channel   Handshake           Payload
// input     start / busy        real_part, imag_part (signed 16 bits)
// result    done (one cycle)    magnitude, phase_angle (unsigned 16 bits)
//
// A new sample may be started in every cycle; busy is high only during reset.
// Each result passes an input register and then the longer of the bit-per-stage square
// root and the rotation chain; the shorter path is padded with registers to match.
// Synchronous reset empties the pipeline; samples in flight are dropped.
// The receiver cannot stall, so the pipeline advances on every clock.
module complex_magnitude_phase #(
  parameter int ROTATION_STAGES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] real_part,
  input  logic signed [15:0] imag_part,
  output logic               done,
  output logic [15:0]        magnitude,
  output logic [15:0]        phase_angle
);

  localparam int ANG_LAT = ROTATION_STAGES + 2;
  localparam int PATH_LAT = (ANG_LAT > cmp_pkg::MAG_LAT) ? ANG_LAT : cmp_pkg::MAG_LAT;
  localparam int MAG_PAD = PATH_LAT - cmp_pkg::MAG_LAT;
  localparam int ANG_PAD = PATH_LAT - ANG_LAT;
  localparam int TOTAL_LAT = PATH_LAT + 1;

  logic signed [16:0] re_ext;
  logic signed [16:0] im_ext;
  logic [cmp_pkg::ABS_W-1:0] ax;
  logic [cmp_pkg::ABS_W-1:0] ay;
  cmp_pkg::quad_t quad;
  logic in_valid;

  logic        mag_valid;
  logic [15:0] mag_raw;
  logic        ang_valid;
  logic [15:0] ang_raw;
  logic        mag_valid_d;
  logic [15:0] mag_d;
  logic        ang_valid_d;
  logic [15:0] ang_d;

  assign busy = rst;
  assign re_ext = {real_part[15], real_part};
  assign im_ext = {imag_part[15], imag_part};

  always_ff @(posedge clk) begin
    ax <= real_part[15] ? unsigned'(-re_ext) : unsigned'(re_ext);
    ay <= imag_part[15] ? unsigned'(-im_ext) : unsigned'(im_ext);
    quad.re_neg <= real_part[15];
    quad.re_zero <= real_part == '0;
    quad.im_neg <= imag_part[15];
    quad.im_zero <= imag_part == '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start;
    end
  end

  cmp_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .ax        (ax),
    .ay        (ay),
    .out_valid (mag_valid),
    .magnitude (mag_raw)
  );

  cmp_cordic #(
    .ROTATION_STAGES (ROTATION_STAGES)
  ) u_cordic (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .ax          (ax),
    .ay          (ay),
    .quad        (quad),
    .out_valid   (ang_valid),
    .phase_angle (ang_raw)
  );

  if (MAG_PAD > 0) begin : g_mag_pad
    logic [MAG_PAD-1:0] vpipe;
    logic [15:0]        dpipe [MAG_PAD];

    always_ff @(posedge clk) begin
      if (rst) begin
        vpipe <= '0;
      end else begin
        vpipe[0] <= mag_valid;
        for (int k = 1; k < MAG_PAD; k++) begin
          vpipe[k] <= vpipe[k-1];
        end
      end
    end

    always_ff @(posedge clk) begin
      dpipe[0] <= mag_raw;
      for (int k = 1; k < MAG_PAD; k++) begin
        dpipe[k] <= dpipe[k-1];
      end
    end

    assign mag_valid_d = vpipe[MAG_PAD-1];
    assign mag_d = dpipe[MAG_PAD-1];
  end else begin : g_mag_direct
    assign mag_valid_d = mag_valid;
    assign mag_d = mag_raw;
  end

  if (ANG_PAD > 0) begin : g_ang_pad
    logic [ANG_PAD-1:0] vpipe;
    logic [15:0]        dpipe [ANG_PAD];

    always_ff @(posedge clk) begin
      if (rst) begin
        vpipe <= '0;
      end else begin
        vpipe[0] <= ang_valid;
        for (int k = 1; k < ANG_PAD; k++) begin
          vpipe[k] <= vpipe[k-1];
        end
      end
    end

    always_ff @(posedge clk) begin
      dpipe[0] <= ang_raw;
      for (int k = 1; k < ANG_PAD; k++) begin
        dpipe[k] <= dpipe[k-1];
      end
    end

    assign ang_valid_d = vpipe[ANG_PAD-1];
    assign ang_d = dpipe[ANG_PAD-1];
  end else begin : g_ang_direct
    assign ang_valid_d = ang_valid;
    assign ang_d = ang_raw;
  end

  assign done = ang_valid_d;
  assign magnitude = mag_d;
  assign phase_angle = ang_d;

  a_paths_aligned: assert property (@(posedge clk) disable iff (rst)
    mag_valid_d == ang_valid_d)
    else $error("magnitude and phase paths out of step");

  a_transfer_completes: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##TOTAL_LAT done)
    else $error("accepted sample produced no result");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, TOTAL_LAT))
    else $error("result without a matching transfer");

  a_magnitude_range: assert property (@(posedge clk) disable iff (rst)
    done |-> magnitude <= cmp_pkg::MAG_MAX)
    else $error("magnitude out of range");

endmodule

// ===== bench/magnitude_phase_checker.sv =====
module magnitude_phase_checker #(
  parameter int STAGES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic signed [15:0] real_part,
  input  logic signed [15:0] imag_part,
  input  logic               done,
  input  logic [15:0]        magnitude,
  input  logic [15:0]        phase_angle,
  output int                 mismatches,
  output int                 pending,
  output int                 compared
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PHASE_FRAC = 13;
  localparam int ANGLE_SHIFT = 32 - PHASE_FRAC;
  localparam int GUARD = 16;

  localparam longint QUARTER_PI = 64'sd3373259426;
  localparam longint HALF_PI = 64'sd6746518852;
  localparam longint PI = 64'sd13493037705;
  localparam longint TWO_PI = 64'sd26986075409;

  typedef struct {
    logic signed [15:0] re;
    logic signed [15:0] im;
    logic [15:0]        mag;
    logic [15:0]        phase;
  } polar_t;

  polar_t expected_polar[$];
  longint arctan_rom[STAGES];
  int fail_count = 0;
  int in_flight = 0;
  int result_count = 0;

  assign mismatches = fail_count;
  assign pending = in_flight;
  assign compared = result_count;

  // Arctangent of 2^-idx from its power series (quarter pi for idx 0), radians with 32 fractional bits.
  function automatic longint arctan_q32(input int idx);
    longint sum;
    longint term;
    sum = 0;
    if (idx == 0) begin
      return QUARTER_PI;
    end
    for (int k = 1; idx * k <= 62; k += 2) begin
      term = longint'((64'd1 << (62 - idx * k)) / longint'(k));
      if (((k - 1) / 2) % 2 == 0) begin
        sum += term;
      end else begin
        sum -= term;
      end
    end
    return (sum + (longint'(1) << 29)) / (longint'(1) << 30);
  endfunction

  initial begin
    for (int i = 0; i < STAGES; i++) begin
      arctan_rom[i] = arctan_q32(i);
    end
  end

  function automatic logic [15:0] rounded_root(input longint unsigned s);
    longint unsigned rem;
    longint unsigned root;
    longint unsigned probe;
    rem = s;
    root = 0;
    probe = 64'd1 << 62;
    while (probe > rem) begin
      probe >>= 2;
    end
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem -= root + probe;
        root = (root >> 1) + probe;
      end else begin
        root >>= 1;
      end
      probe >>= 2;
    end
    if (s - root * root > root) begin
      root++;
    end
    return 16'(root);
  endfunction

  // First-quadrant angle of a vector with both components positive.
  function automatic longint quadrant_angle(input longint ax, input longint ay);
    longint x;
    longint y;
    longint z;
    longint xs;
    longint ys;
    x = ax <<< GUARD;
    y = ay <<< GUARD;
    z = 0;
    for (int i = 0; i < STAGES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys;
        y -= xs;
        z += arctan_rom[i];
      end else begin
        x -= ys;
        y += xs;
        z -= arctan_rom[i];
      end
    end
    if (z < 0) begin
      z = 0;
    end
    if (z > HALF_PI) begin
      z = HALF_PI;
    end
    return z;
  endfunction

  function automatic polar_t predict_polar(input logic signed [15:0] re,
                                           input logic signed [15:0] im);
    polar_t p;
    longint ax;
    longint ay;
    longint acc;
    longint theta;
    longint code;
    longint top;
    ax = (re < 0) ? -longint'(re) : longint'(re);
    ay = (im < 0) ? -longint'(im) : longint'(im);
    p.re = re;
    p.im = im;
    p.mag = rounded_root(longint'(ax * ax + ay * ay));
    if (re == 0 && im == 0) begin
      acc = 0;
    end else if (im == 0) begin
      acc = (re > 0) ? 0 : PI;
    end else if (re == 0) begin
      acc = (im > 0) ? HALF_PI : PI + HALF_PI;
    end else begin
      theta = quadrant_angle(ax, ay);
      if (re > 0 && im > 0) begin
        acc = theta;
      end else if (re < 0 && im > 0) begin
        acc = PI - theta;
      end else if (re < 0) begin
        acc = PI + theta;
      end else begin
        acc = TWO_PI - theta;
      end
    end
    code = (acc + (longint'(1) << (ANGLE_SHIFT - 1))) >>> ANGLE_SHIFT;
    top = TWO_PI >>> ANGLE_SHIFT;
    if (code > top) begin
      code = top;
    end
    p.phase = 16'(code);
    return p;
  endfunction

  task automatic report_mismatch(input string msg);
    fail_count++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    polar_t want;
    if (!rst) begin
      if (done) begin
        if (expected_polar.size() == 0) begin
          report_mismatch($sformatf("result %0d / %0d with no transfer outstanding",
                                    magnitude, phase_angle));
        end else begin
          want = expected_polar.pop_front();
          result_count++;
          if (magnitude !== want.mag) begin
            report_mismatch($sformatf("magnitude for (%0d, %0d): got %0d, expected %0d",
                                      want.re, want.im, magnitude, want.mag));
          end
          if (phase_angle !== want.phase) begin
            report_mismatch($sformatf("phase for (%0d, %0d): got %0d, expected %0d",
                                      want.re, want.im, phase_angle, want.phase));
          end
        end
      end
      if (start && !busy) begin
        expected_polar.push_back(predict_polar(real_part, imag_part));
      end
      in_flight = expected_polar.size();
    end
  end

endmodule

// ===== bench/complex_magnitude_phase_tb.sv =====
module complex_magnitude_phase_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STAGES = 16;
  localparam int LATENCY = (STAGES + 3 > 20) ? STAGES + 3 : 20;
  localparam int RANDOM_ITEMS = 1200;
  localparam int WATCHDOG_LIMIT = 2000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic signed [15:0] real_part = '0;
  logic signed [15:0] imag_part = '0;
  logic               busy;
  logic               done;
  logic [15:0]        magnitude;
  logic [15:0]        phase_angle;

  int  mismatches;
  int  pending;
  int  compared;
  int  sent = 0;
  int  directed = 0;
  int  stalled_cycles = 0;
  bit  taken = 1'b0;

  always #5 clk = ~clk;

  complex_magnitude_phase #(
    .ROTATION_STAGES(STAGES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .real_part(real_part),
    .imag_part(imag_part),
    .done(done),
    .magnitude(magnitude),
    .phase_angle(phase_angle)
  );

  magnitude_phase_checker #(
    .STAGES(STAGES)
  ) polar_check (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .real_part(real_part),
    .imag_part(imag_part),
    .done(done),
    .magnitude(magnitude),
    .phase_angle(phase_angle),
    .mismatches(mismatches),
    .pending(pending),
    .compared(compared)
  );

  always @(posedge clk) begin
    taken <= start && !busy && !rst;
  end

  always @(posedge clk) begin
    if ((start && !busy && !rst) || done) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles >= WATCHDOG_LIMIT) begin
      $display("complex_magnitude_phase regression: fail");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_sample(input logic signed [15:0] re, input logic signed [15:0] im,
                             input bit may_idle);
    if (may_idle && $urandom_range(0, 99) < 5) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    real_part <= re;
    imag_part <= im;
    start <= 1'b1;
    do @(negedge clk); while (!taken);
    sent++;
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic signed [15:0] extreme_part();
    case ($urandom_range(0, 6))
      0: return 16'sh8000;
      1: return 16'sh8001;
      2: return -16'sd1;
      3: return 16'sd0;
      4: return 16'sd1;
      5: return 16'sh7ffe;
      default: return 16'sh7fff;
    endcase
  endfunction

  task automatic pick_sample(output logic signed [15:0] re, output logic signed [15:0] im);
    int kind;
    logic signed [15:0] big;
    logic signed [15:0] tiny;
    logic [15:0] a;
    logic [15:0] b;
    kind = $urandom_range(0, 99);
    if (kind < 40) begin
      re = 16'($urandom);
      im = 16'($urandom);
    end else if (kind < 55) begin
      re = 16'($urandom_range(0, 32) - 16);
      im = 16'($urandom_range(0, 32) - 16);
    end else if (kind < 65) begin
      big = 16'($urandom);
      if ($urandom_range(0, 1)) begin
        re = big;
        im = '0;
      end else begin
        re = '0;
        im = big;
      end
    end else if (kind < 75) begin
      big = 16'($urandom);
      tiny = 16'($urandom_range(0, 6) - 3);
      if ($urandom_range(0, 1)) begin
        re = big;
        im = tiny;
      end else begin
        re = tiny;
        im = big;
      end
    end else if (kind < 85) begin
      re = extreme_part();
      im = extreme_part();
    end else begin
      a = 16'($urandom_range(0, 32767));
      b = 16'(a + $urandom_range(0, 2) - 1);
      re = $urandom_range(0, 1) ? -$signed(a) : $signed(a);
      im = $urandom_range(0, 1) ? -$signed(b) : $signed(b);
    end
  endtask

  initial begin
    logic signed [15:0] re;
    logic signed [15:0] im;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_sample(16'sd0, 16'sd0, 1'b0);
    send_sample(16'sh7fff, 16'sd0, 1'b0);
    send_sample(16'sh8000, 16'sd0, 1'b0);
    send_sample(16'sd0, 16'sh7fff, 1'b0);
    send_sample(16'sd0, 16'sh8000, 1'b0);
    send_sample(16'sd1, 16'sd0, 1'b0);
    send_sample(-16'sd1, 16'sd0, 1'b0);
    send_sample(16'sd0, 16'sd1, 1'b0);
    send_sample(16'sd0, -16'sd1, 1'b0);
    send_sample(16'sd1, 16'sd1, 1'b0);
    send_sample(-16'sd1, 16'sd1, 1'b0);
    send_sample(-16'sd1, -16'sd1, 1'b0);
    send_sample(16'sd1, -16'sd1, 1'b0);
    send_sample(16'sh8000, 16'sh8000, 1'b0);
    send_sample(16'sh7fff, 16'sh7fff, 1'b0);
    send_sample(16'sh8000, 16'sh7fff, 1'b0);
    send_sample(16'sh7fff, 16'sh8000, 1'b0);
    send_sample(16'sh7fff, -16'sd1, 1'b0);
    send_sample(16'sh8000, 16'sd1, 1'b0);
    send_sample(16'sh8000, -16'sd1, 1'b0);
    send_sample(16'sd3, 16'sd4, 1'b0);
    send_sample(-16'sd5, -16'sd12, 1'b0);
    directed = sent;
    drain_results();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 800) begin
        drain_results();
      end
      pick_sample(re, im);
      send_sample(re, im, !(n >= 400 && n < 700));
    end

    start <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);

    $display("%0d samples sent (%0d directed), %0d results compared.", sent, directed,
             compared);
    $display("Covered axes, extremes, near-axis and diagonal vectors with random sender gaps.");
    if (mismatches == 0 && pending == 0) begin
      $display("complex_magnitude_phase regression: pass");
    end else begin
      $display("complex_magnitude_phase regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/cmp_pkg.sv
sv/cmp_sqrt.sv
sv/cmp_cordic.sv
sv/complex_magnitude_phase.sv
bench/magnitude_phase_checker.sv
bench/complex_magnitude_phase_tb.sv
